// ===== src/ubr_pkg.sv =====
// Shared types, constants and helpers for the UART byte receiver.
package ubr_pkg;

  localparam int unsigned DataBitsDflt   = 8;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned TickW          = 16;
  localparam int unsigned ApbDataW       = 32;
  localparam int unsigned ApbAddrW       = 3;

  localparam logic [TickW-1:0] StartDelayRst = 16'd29;
  localparam logic [TickW-1:0] BitPeriodRst  = 16'd26;

  typedef enum logic {
    REG_START_DELAY = 1'b0,
    REG_BIT_PERIOD  = 1'b1
  } ubr_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RECV = 1'b1
  } ubr_state_e;

  typedef struct packed {
    logic             busy;
    logic             emit;
    logic [ByteW-1:0] data;
  } ubr_result_t;

  // a programmed zero counts as one tick
  function automatic logic [TickW-1:0] ubr_load(input logic [TickW-1:0] v);
    ubr_load = (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

// ===== src/ubr_rx_core.sv =====
// Receive state machine, tick countdown and data shift register.
module ubr_rx_core #(
  parameter int unsigned DATA_BITS = ubr_pkg::DataBitsDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic                        level_i,
  input  logic [ubr_pkg::TickW-1:0]   start_delay_i,
  input  logic [ubr_pkg::TickW-1:0]   bit_period_i,
  output ubr_pkg::ubr_result_t        result_o
);
  import ubr_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_BITS + 1);

  ubr_state_e           state_q, state_d;
  logic                 prev_q, prev_d;
  logic [TickW-1:0]     cnt_q, cnt_d, cnt_dec;
  logic [CntW-1:0]      bits_q, bits_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic                 start_edge, cnt_zero, bits_full, emit;

  assign cnt_dec    = (cnt_q != '0) ? cnt_q - TickW'(1) : '0;
  assign cnt_zero   = (cnt_dec == '0);
  assign bits_full  = (bits_q >= CntW'(DATA_BITS));
  assign start_edge = prev_q && !level_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tick_i && start_edge) state_d = ST_RECV;
      ST_RECV: if (tick_i && cnt_zero && bits_full) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    emit    = 1'b0;
    if (tick_i) begin
      prev_d = level_i;
      unique case (state_q)
        ST_IDLE: begin
          if (start_edge) begin
            cnt_d  = ubr_load(start_delay_i);
            bits_d = '0;
          end
        end
        ST_RECV: begin
          cnt_d = cnt_dec;
          if (cnt_zero) begin
            if (!bits_full) begin
              shift_d = {level_i, shift_q[DATA_BITS-1:1]};
              bits_d  = bits_q + CntW'(1);
              cnt_d   = ubr_load(bit_period_i);
            end else begin
              bits_d = '0;
              emit   = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q  <= 1'b1;
      cnt_q   <= '0;
      bits_q  <= '0;
      shift_q <= '0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
    end
  end

  assign result_o.busy = (state_q == ST_RECV);
  assign result_o.emit = emit;
  assign result_o.data = ByteW'(shift_q);

endmodule

// ===== src/uart_byte_receiver.sv =====
// UART byte receiver top level: config registers, receive core, output register.
// Takes one line sample per transfer and can take a transfer every clock cycle:
// each sample is worked in one pass through the receive core and a finished byte
// lands in an output register, so input stalls only while that register is full
// and not being drained. A falling edge while idle starts a reception; the first
// data bit is sampled start_delay_ticks samples later (address 0x0), the rest
// every bit_period_ticks samples (address 0x4), LSB first, and the byte is
// delivered one bit period after the last data bit. A zero register value acts
// as one. Start and stop bits are not checked and edges during reception are
// ignored.
module uart_byte_receiver #(
  parameter int unsigned DATA_BITS = ubr_pkg::DataBitsDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          rx_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ubr_pkg::ByteW-1:0]     received_byte_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ubr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ubr_pkg::ApbDataW-1:0]  pwdata,
  output logic [ubr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import ubr_pkg::*;

  logic [TickW-1:0] start_delay_q, bit_period_q;
  logic             cfg_we, accept;
  ubr_reg_e         reg_sel;
  ubr_result_t      rx_res;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q, out_data_d;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = ubr_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= StartDelayRst;
      bit_period_q  <= BitPeriodRst;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_START_DELAY: start_delay_q <= pwdata[TickW-1:0];
        REG_BIT_PERIOD:  bit_period_q  <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_DELAY: prdata = ApbDataW'(start_delay_q);
      REG_BIT_PERIOD:  prdata = ApbDataW'(bit_period_q);
      default:         prdata = '0;
    endcase
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ubr_rx_core #(
    .DATA_BITS(DATA_BITS)
  ) u_rx_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (accept),
    .level_i      (rx_level_i),
    .start_delay_i(start_delay_q),
    .bit_period_i (bit_period_q),
    .result_o     (rx_res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (accept && rx_res.emit) begin
      out_valid_d = 1'b1;
      out_data_d  = rx_res.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign received_byte_o = out_data_q;

`ifndef SYNTHESIS
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_res.busy |-> !rx_res.emit)
    else $error("byte emitted while idle");

  a_emit_ends_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_res.emit |=> !rx_res.busy && out_valid_o)
    else $error("emission did not end reception or fill output");

  a_upper_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (received_byte_o >> DATA_BITS) == '0)
    else $error("byte bits above data width not zero");
`endif

endmodule
